[rtl/bldc_hall_commutation_controller_core_defines.svh]
// Assertion macros used by the checker file of the hall commutation controller
`ifndef BLDC_HALL_COMMUTATION_CONTROLLER_CORE_DEFINES_SVH
`define BLDC_HALL_COMMUTATION_CONTROLLER_CORE_DEFINES_SVH

// Clocked property, dropped while reset is asserted
`define BHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold whenever a result request is presented
`define BHC_ASSERT_ON_VALID(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (cond)) \
        else $error(msg);

`endif

[rtl/bhc_pkg.sv]
// Shared types, constants and the commutation table of the hall commutation controller
`default_nettype none

package bhc_pkg;

    localparam int DUTY_W   = 8;
    localparam int HALL_W   = 3;
    localparam int SAMPLE_W = 10;
    localparam int PERIOD_W = 16;
    localparam int CFG_W    = 16;
    localparam int PHASES   = 3;

    localparam logic [DUTY_W-1:0]   THRESHOLD_RESET = 8'd51;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd100;

    // Register indexes of the configuration port
    localparam logic CFG_THROTTLE_THRESHOLD = 1'b0;
    localparam logic CFG_BLINK_PERIOD       = 1'b1;

    // Request kinds
    localparam logic OP_HALL_CHANGE = 1'b0;
    localparam logic OP_TICK        = 1'b1;

    // Hall codes, bit2 W, bit1 V, bit0 U
    localparam logic [HALL_W-1:0] HALL_U_HI_V_LO = 3'd5;
    localparam logic [HALL_W-1:0] HALL_U_HI_W_LO = 3'd1;
    localparam logic [HALL_W-1:0] HALL_V_HI_W_LO = 3'd3;
    localparam logic [HALL_W-1:0] HALL_V_HI_U_LO = 3'd2;
    localparam logic [HALL_W-1:0] HALL_W_HI_U_LO = 3'd6;
    localparam logic [HALL_W-1:0] HALL_W_HI_V_LO = 3'd4;

    typedef struct packed {
        logic                operation;
        logic [HALL_W-1:0]   hall_code;
        logic [SAMPLE_W-1:0] throttle_sample;
    } item_t;

    // Switch state: index 0 = U, 1 = V, 2 = W
    typedef struct packed {
        logic [PHASES-1:0][DUTY_W-1:0] hi_duty;
        logic [PHASES-1:0]             lo_on;
    } switch_t;

    typedef struct packed {
        switch_t           sw;
        logic [HALL_W-1:0] hall_leds;
        logic              heartbeat_led;
        logic              drive_active;
    } result_t;

    localparam switch_t SWITCH_OFF = '0;

    // Six-step table: one high side carries the duty, one low side on; else all off
    function automatic switch_t commutate(input logic [HALL_W-1:0] code,
                                          input logic [DUTY_W-1:0] duty);
        switch_t sw;
        sw = SWITCH_OFF;
        unique case (code)
            HALL_U_HI_V_LO:
            begin
                sw.hi_duty[0] = duty;
                sw.lo_on[1]   = 1'b1;
            end
            HALL_U_HI_W_LO:
            begin
                sw.hi_duty[0] = duty;
                sw.lo_on[2]   = 1'b1;
            end
            HALL_V_HI_W_LO:
            begin
                sw.hi_duty[1] = duty;
                sw.lo_on[2]   = 1'b1;
            end
            HALL_V_HI_U_LO:
            begin
                sw.hi_duty[1] = duty;
                sw.lo_on[0]   = 1'b1;
            end
            HALL_W_HI_U_LO:
            begin
                sw.hi_duty[2] = duty;
                sw.lo_on[0]   = 1'b1;
            end
            HALL_W_HI_V_LO:
            begin
                sw.hi_duty[2] = duty;
                sw.lo_on[1]   = 1'b1;
            end
            default:
            begin
                sw = SWITCH_OFF;
            end
        endcase
        return sw;
    endfunction

endpackage

`default_nettype wire

[rtl/bhc_engine.sv]
// Controller state, configuration registers and per-request next-state logic
`default_nettype none

module bhc_engine #(
    parameter logic [bhc_pkg::DUTY_W-1:0]   THRESHOLD_INIT = bhc_pkg::THRESHOLD_RESET,
    parameter logic [bhc_pkg::PERIOD_W-1:0] PERIOD_INIT    = bhc_pkg::PERIOD_RESET
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write_en,
    input  wire logic                      cfg_index,
    input  wire logic [bhc_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      step_en,
    input  wire bhc_pkg::item_t            item,
    output bhc_pkg::result_t               result
);
    import bhc_pkg::*;

    logic [DUTY_W-1:0]   threshold_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [DUTY_W-1:0]   duty_reg,   duty_next;
    logic                drive_reg,  drive_next;
    switch_t             sw_reg,     sw_next;
    logic [HALL_W-1:0]   led_reg,    led_next;
    logic [PERIOD_W-1:0] count_reg,  count_next;
    logic                toggle_reg, toggle_next;
    logic                pilot_reg,  pilot_next;

    logic [DUTY_W-1:0]   sample_duty;
    logic [PERIOD_W:0]   count_inc;

    assign sample_duty = item.throttle_sample[SAMPLE_W-1:2];
    assign count_inc   = {1'b0, count_reg} + {{PERIOD_W{1'b0}}, 1'b1};

    // Apply one request to the state
    always_comb
    begin
        duty_next   = duty_reg;
        drive_next  = drive_reg;
        sw_next     = sw_reg;
        led_next    = led_reg;
        count_next  = count_reg;
        toggle_next = toggle_reg;
        pilot_next  = pilot_reg;
        if (item.operation == OP_HALL_CHANGE)
        begin
            sw_next  = commutate(item.hall_code, duty_reg);
            led_next = item.hall_code;
        end
        else
        begin
            // Start or stop the drive on the throttle level
            if (sample_duty > threshold_reg)
            begin
                duty_next = sample_duty;
                if (!drive_reg)
                begin
                    drive_next = 1'b1;
                    sw_next    = commutate(item.hall_code, sample_duty);
                    led_next   = item.hall_code;
                end
            end
            else
            begin
                duty_next  = '0;
                drive_next = 1'b0;
                sw_next    = SWITCH_OFF;
            end
            // Advance the blink counter
            if (count_inc >= {1'b0, period_reg})
            begin
                count_next  = '0;
                pilot_next  = toggle_reg;
                toggle_next = ~toggle_reg;
            end
            else
            begin
                count_next = count_inc[PERIOD_W-1:0];
            end
        end
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_INIT;
            period_reg    <= PERIOD_INIT;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_THROTTLE_THRESHOLD: threshold_reg <= cfg_data[DUTY_W-1:0];
                CFG_BLINK_PERIOD:       period_reg    <= cfg_data[PERIOD_W-1:0];
                default:                threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Hold controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg   <= '0;
            drive_reg  <= 1'b0;
            sw_reg     <= SWITCH_OFF;
            led_reg    <= '0;
            count_reg  <= '0;
            toggle_reg <= 1'b0;
            pilot_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            duty_reg   <= duty_next;
            drive_reg  <= drive_next;
            sw_reg     <= sw_next;
            led_reg    <= led_next;
            count_reg  <= count_next;
            toggle_reg <= toggle_next;
            pilot_reg  <= pilot_next;
        end
    end

    // Result is the state after the request
    always_comb
    begin
        result.sw            = sw_next;
        result.hall_leds     = led_next;
        result.heartbeat_led = pilot_next;
        result.drive_active  = drive_next;
    end

endmodule

`default_nettype wire

[rtl/bldc_hall_commutation_controller_core.sv]
// An accepted request waits in the input register; its result is captured in the
// result register when that stage is free. Throughput: one request per cycle while
// out_ready holds; input and result registers are separate stages, so one more
// request is taken while a finished result waits for out_ready.
// Reset (rst_n low, asynchronous): engine switch state off, duty and drive cleared, counters zero,
// threshold 51 and blink period 100.
`default_nettype none

module bldc_hall_commutation_controller_core #(
    parameter logic [bhc_pkg::DUTY_W-1:0]   THRESHOLD_INIT = bhc_pkg::THRESHOLD_RESET,
    parameter logic [bhc_pkg::PERIOD_W-1:0] PERIOD_INIT    = bhc_pkg::PERIOD_RESET
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic                         cfg_index,
    input  wire logic [bhc_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         operation,
    input  wire logic [bhc_pkg::HALL_W-1:0]   hall_code,
    input  wire logic [bhc_pkg::SAMPLE_W-1:0] throttle_sample,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [bhc_pkg::DUTY_W-1:0]        u_high_duty,
    output logic [bhc_pkg::DUTY_W-1:0]        v_high_duty,
    output logic [bhc_pkg::DUTY_W-1:0]        w_high_duty,
    output logic                              u_low_on,
    output logic                              v_low_on,
    output logic                              w_low_on,
    output logic [bhc_pkg::HALL_W-1:0]        hall_leds,
    output logic                              heartbeat_led,
    output logic                              drive_active
);
    import bhc_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg,  out_valid_next;
    logic    out_free;
    logic    advance;
    logic    in_fire;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    bhc_engine #(
        .THRESHOLD_INIT (THRESHOLD_INIT),
        .PERIOD_INIT    (PERIOD_INIT)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step_en      (advance),
        .item         (item_reg),
        .result       (result_next)
    );

    // Track occupancy of both stages
    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_fire)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.operation       <= operation;
            item_reg.hall_code       <= hall_code;
            item_reg.throttle_sample <= throttle_sample;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign u_high_duty   = result_reg.sw.hi_duty[0];
    assign v_high_duty   = result_reg.sw.hi_duty[1];
    assign w_high_duty   = result_reg.sw.hi_duty[2];
    assign u_low_on      = result_reg.sw.lo_on[0];
    assign v_low_on      = result_reg.sw.lo_on[1];
    assign w_low_on      = result_reg.sw.lo_on[2];
    assign hall_leds     = result_reg.hall_leds;
    assign heartbeat_led = result_reg.heartbeat_led;
    assign drive_active  = result_reg.drive_active;

endmodule

`default_nettype wire

[rtl/bhc_checker.sv]
// Port-level checks of the hall commutation controller and their binding
`default_nettype none

`include "bldc_hall_commutation_controller_core_defines.svh"

module bhc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [bhc_pkg::DUTY_W-1:0]   u_high_duty,
    input wire logic [bhc_pkg::DUTY_W-1:0]   v_high_duty,
    input wire logic [bhc_pkg::DUTY_W-1:0]   w_high_duty,
    input wire logic                         u_low_on,
    input wire logic                         v_low_on,
    input wire logic                         w_low_on,
    input wire logic                         drive_active
);
    import bhc_pkg::*;

    logic [PHASES-1:0] hi_active;

    assign hi_active = {w_high_duty != '0, v_high_duty != '0, u_high_duty != '0};

    // A stalled result request stays up
    `BHC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    // Never more than one high side driving
    `BHC_ASSERT_ON_VALID(a_one_high, $onehot0(hi_active), "two high sides driven")

    // Never more than one low side on
    `BHC_ASSERT_ON_VALID(a_one_low, $onehot0({w_low_on, v_low_on, u_low_on}), "two low sides on")

    // A stopped motor carries no high-side duty, and no phase shoots through
    `BHC_ASSERT_ON_VALID(a_stop_safe,
        (drive_active || hi_active == '0) &&
        ((hi_active & {w_low_on, v_low_on, u_low_on}) == '0),
        "high side driven while stopped or against its own low side")

endmodule

bind bldc_hall_commutation_controller_core bhc_checker u_bhc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .u_high_duty  (u_high_duty),
    .v_high_duty  (v_high_duty),
    .w_high_duty  (w_high_duty),
    .u_low_on     (u_low_on),
    .v_low_on     (v_low_on),
    .w_low_on     (w_low_on),
    .drive_active (drive_active)
);

`default_nettype wire
